// ===== design/bthin_pkg.sv =====
// bthin_pkg: shared constants, codes and types for the binary image thinning block
// used by bthin_agu, bthin_eval, bthin_ctrl and binary_image_thinning
`default_nettype none

package bthin_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(CELLS);

  localparam int DIM_W      = 7;
  localparam int CELL_W     = 2 * DIM_W;
  localparam int PIX_W      = 8;
  localparam int FIELD_AW   = 12;
  localparam int COUNT_W    = 12;
  localparam int FUNC_W     = 2;
  localparam int NB_N       = 8;
  localparam int NB_SUM_W   = 4;
  localparam int STEP_W     = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [STEP_W-1:0]   STEP_LAST = STEP_W'(NB_N + 1);
  localparam logic [NB_SUM_W-1:0] NB_MIN    = NB_SUM_W'(2);
  localparam logic [NB_SUM_W-1:0] NB_MAX    = NB_SUM_W'(6);
  localparam logic [PIX_W-1:0]    FG_VALUE  = PIX_W'(255);
  localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [DIM_W-1:0]    DIM_MIN   = DIM_W'(3);
  localparam logic [DIM_W-1:0]    DIM_EDGE  = DIM_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_THIN = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  // first nine codes follow the neighborhood read order
  typedef enum logic [3:0] {
    AG_C, AG_N, AG_NE, AG_E, AG_SE, AG_S, AG_SW, AG_W, AG_NW,
    AG_NEXT, AG_WRAP, AG_FIRST
  } agu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_SUB_INIT, ST_SCAN, ST_APPLY_INIT,
    ST_APPLY_RD, ST_APPLY_WR, ST_SUB_END, ST_RESULT
  } state_t;

  typedef struct packed {
    logic                start;
    func_t               func;
    logic [ADDR_W-1:0]   addr;
    logic                addr_ok;
    logic                pix_bit;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } dims_t;

endpackage

`default_nettype wire

// ===== design/binary_image_thinning.sv =====
// binary_image_thinning: load and read requests end in a result; next request accepted once idle
// thin: per sub-iteration an init step, a scan of each interior pixel (9 reads on one memory
// port and the decision), then a mark read and write per pixel, two per pass, plus result
// result held in an output register until taken; no new request while a thin runs
// rst_n synchronous: registers to 128/64/64, control cleared, pixel memory not cleared
// depends on bthin_pkg, bthin_ctrl
`default_nettype none

module binary_image_thinning (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [bthin_pkg::IN_DATA_W-1:0]     in_tdata,   // func, address, pixel_value
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [bthin_pkg::OUT_DATA_W-1:0]         out_tdata,  // result_value, pass_count
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [bthin_pkg::PIX_W-1:0]         cfg_data
);

  logic [bthin_pkg::PIX_W-1:0]    threshold_r;
  logic [bthin_pkg::DIM_W-1:0]    image_width_r;
  logic [bthin_pkg::DIM_W-1:0]    image_height_r;

  logic [bthin_pkg::FUNC_W-1:0]   in_func;
  logic [bthin_pkg::FIELD_AW-1:0] in_address;
  logic [bthin_pkg::PIX_W-1:0]    in_pixel_value;

  bthin_pkg::dims_t               dims;
  bthin_pkg::cmd_t                cmd;
  logic [bthin_pkg::CELL_W-1:0]   cells;

  logic                           ctrl_ready;
  logic                           done;
  logic                           out_free;
  logic [bthin_pkg::PIX_W-1:0]    res_value;
  logic [bthin_pkg::COUNT_W-1:0]  res_count;

  logic                           out_valid_r;
  logic [bthin_pkg::OUT_DATA_W-1:0] out_data_r;

  assign in_func        = in_tdata[1:0];
  assign in_address     = in_tdata[13:2];
  assign in_pixel_value = in_tdata[21:14];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= bthin_pkg::PIX_W'(128);
      image_width_r  <= bthin_pkg::DIM_W'(64);
      image_height_r <= bthin_pkg::DIM_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (bthin_pkg::reg_idx_t'(cfg_index))
        bthin_pkg::REG_THRESHOLD: threshold_r    <= cfg_data;
        bthin_pkg::REG_WIDTH:     image_width_r  <= bthin_pkg::DIM_W'(cfg_data);
        bthin_pkg::REG_HEIGHT:    image_height_r <= bthin_pkg::DIM_W'(cfg_data);
        default:                  threshold_r    <= threshold_r;
      endcase
    end
  end

  always_comb begin
    dims.w = (int'(image_width_r) > bthin_pkg::MAX_WIDTH)
             ? bthin_pkg::DIM_W'(bthin_pkg::MAX_WIDTH) : image_width_r;
    dims.h = (int'(image_height_r) > bthin_pkg::MAX_HEIGHT)
             ? bthin_pkg::DIM_W'(bthin_pkg::MAX_HEIGHT) : image_height_r;
    cells  = bthin_pkg::CELL_W'(dims.w) * bthin_pkg::CELL_W'(dims.h);

    cmd.start   = in_tvalid && in_tready;
    cmd.func    = bthin_pkg::func_t'(in_func);
    cmd.addr    = bthin_pkg::ADDR_W'(in_address);
    cmd.addr_ok = bthin_pkg::CELL_W'(in_address) < cells;
    cmd.pix_bit = in_pixel_value >= threshold_r;
  end

  assign in_tready = ctrl_ready;
  assign out_free  = !out_valid_r || out_tready;

  bthin_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .dims      (dims),
    .out_free  (out_free),
    .ready     (ctrl_ready),
    .done      (done),
    .res_value (res_value),
    .res_count (res_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= bthin_pkg::OUT_DATA_W'({res_count, res_value});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== design/bthin_agu.sv =====
// bthin_agu: shared address unit, base plus a row and a column offset
// depends on bthin_pkg
`default_nettype none

module bthin_agu (
  input  wire bthin_pkg::agu_op_t           op,
  input  wire logic [bthin_pkg::ADDR_W-1:0] base,
  input  wire logic [bthin_pkg::DIM_W-1:0]  width,
  output logic      [bthin_pkg::ADDR_W-1:0] addr
);

  logic                         up;
  logic                         dn;
  logic signed [2:0]            dx;
  logic [bthin_pkg::ADDR_W-1:0] wz;
  logic [bthin_pkg::ADDR_W-1:0] row_term;
  logic [bthin_pkg::ADDR_W-1:0] col_term;

  always_comb begin
    up = 1'b0;
    dn = 1'b0;
    dx = 3'sd0;
    case (op)
      bthin_pkg::AG_C:     dx = 3'sd0;
      bthin_pkg::AG_N:     up = 1'b1;
      bthin_pkg::AG_NE: begin
        up = 1'b1;
        dx = 3'sd1;
      end
      bthin_pkg::AG_E:     dx = 3'sd1;
      bthin_pkg::AG_SE: begin
        dn = 1'b1;
        dx = 3'sd1;
      end
      bthin_pkg::AG_S:     dn = 1'b1;
      bthin_pkg::AG_SW: begin
        dn = 1'b1;
        dx = -3'sd1;
      end
      bthin_pkg::AG_W:     dx = -3'sd1;
      bthin_pkg::AG_NW: begin
        up = 1'b1;
        dx = -3'sd1;
      end
      bthin_pkg::AG_NEXT:  dx = 3'sd1;
      // skip right border and left border of the next row
      bthin_pkg::AG_WRAP:  dx = 3'sd3;
      bthin_pkg::AG_FIRST: begin
        dn = 1'b1;
        dx = 3'sd1;
      end
      default:             dx = 3'sd0;
    endcase
  end

  always_comb begin
    wz       = bthin_pkg::ADDR_W'(width);
    row_term = dn ? wz : (up ? (bthin_pkg::ADDR_W'(0) - wz) : '0);
    col_term = {{(bthin_pkg::ADDR_W-3){dx[2]}}, dx};
    addr     = base + row_term + col_term;
  end

endmodule

`default_nettype wire

// ===== design/bthin_eval.sv =====
// bthin_eval: zhang-suen deletion decision for one 3x3 neighborhood
// depends on bthin_pkg
`default_nettype none

module bthin_eval (
  input  wire logic                         center,
  input  wire logic [bthin_pkg::NB_N-1:0]   nb,     // N, NE, E, SE, S, SW, W, NW
  input  wire logic                         second,
  output logic                              del
);

  logic [bthin_pkg::NB_SUM_W-1:0] b_sum;
  logic [bthin_pkg::NB_SUM_W-1:0] a_sum;
  logic                           keep;

  always_comb begin
    b_sum = '0;
    a_sum = '0;
    for (int k = 0; k < bthin_pkg::NB_N; k++) begin
      b_sum = b_sum + bthin_pkg::NB_SUM_W'(nb[k]);
      if (!nb[k] && nb[(k + 1) % bthin_pkg::NB_N]) begin
        a_sum = a_sum + bthin_pkg::NB_SUM_W'(1);
      end
    end
    if (second) begin
      keep = (nb[0] & nb[2] & nb[6]) | (nb[0] & nb[4] & nb[6]);
    end else begin
      keep = (nb[0] & nb[2] & nb[4]) | (nb[2] & nb[4] & nb[6]);
    end
    del = center && (b_sum >= bthin_pkg::NB_MIN) && (b_sum <= bthin_pkg::NB_MAX)
          && (a_sum == bthin_pkg::NB_SUM_W'(1)) && !keep;
  end

endmodule

`default_nettype wire

// ===== design/bthin_ctrl.sv =====
// bthin_ctrl: sequencer, pixel grid and delete mark memories
// depends on bthin_pkg, bthin_agu, bthin_eval
`default_nettype none

module bthin_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bthin_pkg::cmd_t                 cmd,
  input  wire bthin_pkg::dims_t                dims,
  input  wire logic                            out_free,
  output logic                                 ready,
  output logic                                 done,
  output logic [bthin_pkg::PIX_W-1:0]          res_value,
  output logic [bthin_pkg::COUNT_W-1:0]        res_count
);

  bthin_pkg::state_t state_r, state_nxt;

  logic [bthin_pkg::ADDR_W-1:0]  c_r, c_nxt;
  logic [bthin_pkg::DIM_W-1:0]   x_r, x_nxt;
  logic [bthin_pkg::DIM_W-1:0]   y_r, y_nxt;
  logic [bthin_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [bthin_pkg::NB_N-1:0]    nbh_r, nbh_nxt;
  logic                          second_r, second_nxt;
  logic                          changed_r, changed_nxt;
  logic [bthin_pkg::COUNT_W-1:0] passes_r, passes_nxt;
  logic                          rd_ok_r, rd_ok_nxt;
  logic                          res_fg_r, res_fg_nxt;
  logic [bthin_pkg::COUNT_W-1:0] res_count_r, res_count_nxt;

  logic                          grid_mem [bthin_pkg::CELLS];
  logic                          mark_mem [bthin_pkg::CELLS];
  logic                          grid_q;
  logic                          mark_q;

  logic                          grid_we, grid_wbit, grid_re;
  logic [bthin_pkg::ADDR_W-1:0]  grid_waddr, grid_raddr;
  logic                          mark_we, mark_wbit, mark_re;

  bthin_pkg::agu_op_t            agu_op;
  logic [bthin_pkg::ADDR_W-1:0]  agu_base;
  logic [bthin_pkg::ADDR_W-1:0]  agu_addr;

  logic                          del;
  logic                          last_x, last_y, interior_ok, scan_last;
  logic [bthin_pkg::COUNT_W-1:0] passes_inc;
  logic [2:0]                    nb_idx;

  bthin_agu u_agu (
    .op    (agu_op),
    .base  (agu_base),
    .width (dims.w),
    .addr  (agu_addr)
  );

  bthin_eval u_eval (
    .center (nbh_r[0]),
    .nb     ({grid_q, nbh_r[bthin_pkg::NB_N-1:1]}),
    .second (second_r),
    .del    (del)
  );

  assign last_x      = (x_r == (dims.w - bthin_pkg::DIM_EDGE));
  assign last_y      = (y_r == (dims.h - bthin_pkg::DIM_EDGE));
  assign interior_ok = (dims.w >= bthin_pkg::DIM_MIN) && (dims.h >= bthin_pkg::DIM_MIN);
  assign scan_last   = (cnt_r == bthin_pkg::STEP_LAST);
  assign passes_inc  = (passes_r == bthin_pkg::COUNT_MAX) ? passes_r
                       : passes_r + bthin_pkg::COUNT_W'(1);
  assign nb_idx      = 3'(cnt_r - bthin_pkg::STEP_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bthin_pkg::ST_IDLE: begin
        if (cmd.start) begin
          case (cmd.func)
            bthin_pkg::FUNC_THIN: state_nxt = bthin_pkg::ST_SUB_INIT;
            bthin_pkg::FUNC_READ: state_nxt = bthin_pkg::ST_READ;
            default:              state_nxt = bthin_pkg::ST_RESULT;
          endcase
        end
      end
      bthin_pkg::ST_READ:       state_nxt = bthin_pkg::ST_RESULT;
      bthin_pkg::ST_SUB_INIT: begin
        state_nxt = interior_ok ? bthin_pkg::ST_SCAN : bthin_pkg::ST_SUB_END;
      end
      bthin_pkg::ST_SCAN: begin
        if (scan_last && last_x && last_y) state_nxt = bthin_pkg::ST_APPLY_INIT;
      end
      bthin_pkg::ST_APPLY_INIT: state_nxt = bthin_pkg::ST_APPLY_RD;
      bthin_pkg::ST_APPLY_RD:   state_nxt = bthin_pkg::ST_APPLY_WR;
      bthin_pkg::ST_APPLY_WR: begin
        state_nxt = (last_x && last_y) ? bthin_pkg::ST_SUB_END : bthin_pkg::ST_APPLY_RD;
      end
      bthin_pkg::ST_SUB_END: begin
        if (!second_r || changed_r) state_nxt = bthin_pkg::ST_SUB_INIT;
        else                        state_nxt = bthin_pkg::ST_RESULT;
      end
      bthin_pkg::ST_RESULT: begin
        if (out_free) state_nxt = bthin_pkg::ST_IDLE;
      end
      default: state_nxt = bthin_pkg::ST_IDLE;
    endcase
  end

  // outputs, memory controls and datapath
  always_comb begin
    ready      = (state_r == bthin_pkg::ST_IDLE);
    done       = (state_r == bthin_pkg::ST_RESULT) && out_free;
    grid_we    = 1'b0;
    grid_wbit  = 1'b0;
    grid_waddr = c_r;
    grid_re    = 1'b0;
    grid_raddr = agu_addr;
    mark_we    = 1'b0;
    mark_wbit  = del;
    mark_re    = 1'b0;
    agu_op     = bthin_pkg::AG_C;
    agu_base   = c_r;

    c_nxt         = c_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    cnt_nxt       = cnt_r;
    nbh_nxt       = nbh_r;
    second_nxt    = second_r;
    changed_nxt   = changed_r;
    passes_nxt    = passes_r;
    rd_ok_nxt     = rd_ok_r;
    res_fg_nxt    = res_fg_r;
    res_count_nxt = res_count_r;

    case (state_r)
      bthin_pkg::ST_IDLE: begin
        if (cmd.start) begin
          res_fg_nxt    = 1'b0;
          res_count_nxt = '0;
          passes_nxt    = '0;
          second_nxt    = 1'b0;
          changed_nxt   = 1'b0;
          rd_ok_nxt     = cmd.addr_ok;
          grid_waddr    = cmd.addr;
          grid_wbit     = cmd.pix_bit;
          grid_we       = (cmd.func == bthin_pkg::FUNC_LOAD) && cmd.addr_ok;
          grid_raddr    = cmd.addr;
          grid_re       = (cmd.func == bthin_pkg::FUNC_READ) && cmd.addr_ok;
        end
      end
      bthin_pkg::ST_READ: begin
        res_fg_nxt = rd_ok_r & grid_q;
      end
      bthin_pkg::ST_SUB_INIT, bthin_pkg::ST_APPLY_INIT: begin
        agu_op   = bthin_pkg::AG_FIRST;
        agu_base = '0;
        c_nxt    = agu_addr;
        x_nxt    = bthin_pkg::DIM_W'(1);
        y_nxt    = bthin_pkg::DIM_W'(1);
        cnt_nxt  = '0;
      end
      bthin_pkg::ST_SCAN: begin
        if (!scan_last) begin
          agu_op  = bthin_pkg::agu_op_t'(cnt_r);
          grid_re = 1'b1;
          cnt_nxt = cnt_r + bthin_pkg::STEP_W'(1);
          if (cnt_r != '0) nbh_nxt[nb_idx] = grid_q;
        end else begin
          mark_we = 1'b1;
          agu_op  = last_x ? bthin_pkg::AG_WRAP : bthin_pkg::AG_NEXT;
          c_nxt   = agu_addr;
          cnt_nxt = '0;
          if (last_x) begin
            x_nxt = bthin_pkg::DIM_W'(1);
            y_nxt = y_r + bthin_pkg::DIM_W'(1);
          end else begin
            x_nxt = x_r + bthin_pkg::DIM_W'(1);
          end
        end
      end
      bthin_pkg::ST_APPLY_RD: begin
        mark_re = 1'b1;
      end
      bthin_pkg::ST_APPLY_WR: begin
        grid_we = mark_q;
        if (mark_q) changed_nxt = 1'b1;
        agu_op = last_x ? bthin_pkg::AG_WRAP : bthin_pkg::AG_NEXT;
        c_nxt  = agu_addr;
        if (last_x) begin
          x_nxt = bthin_pkg::DIM_W'(1);
          y_nxt = y_r + bthin_pkg::DIM_W'(1);
        end else begin
          x_nxt = x_r + bthin_pkg::DIM_W'(1);
        end
      end
      bthin_pkg::ST_SUB_END: begin
        if (!second_r) begin
          second_nxt = 1'b1;
        end else begin
          second_nxt  = 1'b0;
          passes_nxt  = passes_inc;
          changed_nxt = 1'b0;
          if (!changed_r) res_count_nxt = passes_inc;
        end
      end
      default: begin
        ready = (state_r == bthin_pkg::ST_IDLE);
      end
    endcase
  end

  assign res_value = res_fg_r ? bthin_pkg::FG_VALUE : '0;
  assign res_count = res_count_r;

  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_waddr] <= grid_wbit;
    if (grid_re) grid_q <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[c_r] <= mark_wbit;
    if (mark_re) mark_q <= mark_mem[c_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bthin_pkg::ST_IDLE;
      cnt_r     <= '0;
      second_r  <= 1'b0;
      changed_r <= 1'b0;
      passes_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      second_r  <= second_nxt;
      changed_r <= changed_nxt;
      passes_r  <= passes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r         <= c_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    nbh_r       <= nbh_nxt;
    rd_ok_r     <= rd_ok_nxt;
    res_fg_r    <= res_fg_nxt;
    res_count_r <= res_count_nxt;
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bthin_pkg::STEP_LAST)
    else $error("neighborhood step counter out of range");

  a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bthin_pkg::ST_SCAN && !scan_last) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("neighborhood step did not advance");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == bthin_pkg::ST_IDLE && ready)
    else $error("block not idle after result");

  a_thin_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bthin_pkg::ST_SUB_END && second_r && !changed_r) |=> res_count_r != '0)
    else $error("thin request finished with zero passes");

  a_apply_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (grid_we && state_r != bthin_pkg::ST_IDLE) |-> !grid_wbit)
    else $error("thinning wrote a foreground pixel");

endmodule

`default_nettype wire
